>>> rtl/core/stb_pkg.sv
package stb_pkg;

  localparam int FRAME_BITS   = 24;
  localparam int COUNT_BITS   = FRAME_BITS + 1;
  localparam int MAX_CHANNELS = 8;
  localparam int CH_BITS      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_BITS     = $clog2(MAX_CHANNELS + 1);

  localparam int SAMPLE_BITS  = 16;
  localparam int THR_BITS     = 16;
  localparam int CHCNT_BITS   = 4;
  localparam int LOOP_BITS    = 24;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS = 104;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESHOLD     = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_LOOP_START    = 2'd2,
    REG_LOOP_END      = 2'd3
  } cfg_reg_t;

  // Stream state captured on the final word of a zone.
  typedef struct packed {
    logic [COUNT_BITS-1:0] total;
    logic                  seen;
    logic [FRAME_BITS-1:0] first;
    logic [FRAME_BITS-1:0] last;
  } zone_snap_t;

endpackage

>>> rtl/core/silence_trim_bounds.sv
// Silence trim bounds finder for one interleaved sample zone.
// The slave channel carries one channel sample per word in s_tdata, frames
// interleaved by channel; s_tlast marks the last sample of the zone. Each
// complete frame is loud when any channel magnitude reaches the threshold.
// On the last word the master channel delivers one result word: the first
// kept frame, the kept frame count and the loop points moved into that
// range, with m_tuser set when a trim applies. Words without s_tlast give
// no result.
// The accepted last word passes through an input register, a register that
// captures the zone counters, and the result register before m_tvalid.
// Throughput is one word per cycle unless a last word backs up, set by the
// per-sample compare and frame counter update in the input stage. A result
// waiting on m_tready does not stop further samples; only a further last
// word backs up once both result-side registers are full.
// Configuration goes in through wr_en, wr_index and wr_data; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset clears the stream state and sets threshold 0, one channel, loop
// points 0. The stream state also clears itself after each last word.
module silence_trim_bounds (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [stb_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [stb_pkg::CFG_DATA_BITS-1:0] wr_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: [15:0] sample
  input  logic [stb_pkg::IN_DATA_BITS-1:0]  s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: [23:0] keep_first, [48:24] keep_frames, [72:49] new_loop_start,
  //          [96:73] new_loop_end, [103:97] zero
  output logic [stb_pkg::OUT_DATA_BITS-1:0] m_tdata,
  // m_tuser: [0] trimmed
  output logic                              m_tuser
);
  import stb_pkg::*;

  // Configuration registers.
  logic [THR_BITS-1:0]   threshold;
  logic [CHCNT_BITS-1:0] channel_count;
  logic [LOOP_BITS-1:0]  loop_start;
  logic [LOOP_BITS-1:0]  loop_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= '0;
      channel_count <= CHCNT_BITS'(1);
      loop_start    <= '0;
      loop_end      <= '0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_THRESHOLD:     threshold     <= wr_data[THR_BITS-1:0];
        REG_CHANNEL_COUNT: channel_count <= wr_data[CHCNT_BITS-1:0];
        REG_LOOP_START:    loop_start    <= wr_data[LOOP_BITS-1:0];
        REG_LOOP_END:      loop_end      <= wr_data[LOOP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake.
  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   in_final;
  logic                   snap_valid;
  zone_snap_t             snap;

  logic out_free;
  logic snap_free;
  logic snap_move;
  logic in_move;

  assign out_free  = !m_tvalid || m_tready;
  assign snap_move = snap_valid && out_free;
  assign snap_free = !snap_valid || out_free;
  assign in_move   = in_valid && (!in_final || snap_free);
  assign s_tready  = !in_valid || in_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_sample <= s_tdata[SAMPLE_BITS-1:0];
      in_final  <= s_tlast;
    end
  end

  // Per-sample stream state.
  logic [CH_BITS-1:0]    channel_index;
  logic [COUNT_BITS-1:0] frame_index;
  logic                  frame_loud;
  logic [FRAME_BITS-1:0] first_loud;
  logic                  seen_loud;
  logic [FRAME_BITS-1:0] last_loud;

  logic [CH_BITS-1:0]    channel_index_next;
  logic [COUNT_BITS-1:0] frame_index_next;
  logic                  frame_loud_next;
  logic [FRAME_BITS-1:0] first_loud_next;
  logic                  seen_loud_next;
  logic [FRAME_BITS-1:0] last_loud_next;

  logic [SAMPLE_BITS:0] mag;
  logic                 loud;
  logic [CNT_BITS-1:0]  act;
  logic [CH_BITS-1:0]   chi;
  logic                 frame_done;
  logic                 any_loud;

  always_comb begin
    // The magnitude of the most negative sample needs the extra bit.
    mag = in_sample[SAMPLE_BITS-1] ? ((SAMPLE_BITS+1)'(0) - {in_sample[SAMPLE_BITS-1], in_sample})
                                   : {1'b0, in_sample};
    loud = mag >= {1'b0, threshold};

    if (channel_count == '0) begin
      act = CNT_BITS'(1);
    end else if (channel_count > CHCNT_BITS'(MAX_CHANNELS)) begin
      act = CNT_BITS'(MAX_CHANNELS);
    end else begin
      act = CNT_BITS'(channel_count);
    end

    // A channel count lowered mid zone restarts the channel position.
    chi = (CNT_BITS'(channel_index) >= act) ? '0 : channel_index;
    frame_done = (CNT_BITS'(chi) + CNT_BITS'(1)) >= act;
    any_loud = frame_loud || loud;

    channel_index_next = chi + CH_BITS'(1);
    frame_index_next   = frame_index;
    frame_loud_next    = any_loud;
    first_loud_next    = first_loud;
    seen_loud_next     = seen_loud;
    last_loud_next     = last_loud;

    if (frame_done) begin
      channel_index_next = '0;
      frame_loud_next    = 1'b0;
      // Once the counter is full, further frames are dropped.
      if (!frame_index[COUNT_BITS-1]) begin
        if (any_loud) begin
          if (!seen_loud) begin
            first_loud_next = frame_index[FRAME_BITS-1:0];
            seen_loud_next  = 1'b1;
          end
          last_loud_next = frame_index[FRAME_BITS-1:0];
        end
        frame_index_next = frame_index + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= '0;
      frame_index   <= '0;
      frame_loud    <= 1'b0;
      first_loud    <= '0;
      seen_loud     <= 1'b0;
      last_loud     <= '0;
    end else if (in_move) begin
      if (in_final) begin
        channel_index <= '0;
        frame_index   <= '0;
        frame_loud    <= 1'b0;
        first_loud    <= '0;
        seen_loud     <= 1'b0;
        last_loud     <= '0;
      end else begin
        channel_index <= channel_index_next;
        frame_index   <= frame_index_next;
        frame_loud    <= frame_loud_next;
        first_loud    <= first_loud_next;
        seen_loud     <= seen_loud_next;
        last_loud     <= last_loud_next;
      end
    end
  end

  // Zone snapshot taken on the final word.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_move && in_final) begin
      snap_valid <= 1'b1;
    end else if (snap_move) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move && in_final) begin
      snap.total <= frame_index_next;
      snap.seen  <= seen_loud_next;
      snap.first <= first_loud_next;
      snap.last  <= last_loud_next;
    end
  end

  // Trim bounds from the snapshot.
  logic [FRAME_BITS-1:0] first;
  logic [FRAME_BITS-1:0] last;
  logic                  trim;
  logic [FRAME_BITS-1:0] span;
  logic [FRAME_BITS-1:0] end_off;
  logic                  res_trim;
  logic [FRAME_BITS-1:0] res_first;
  logic [COUNT_BITS-1:0] res_kept;
  logic [FRAME_BITS-1:0] res_nls;
  logic [FRAME_BITS-1:0] res_nle;

  always_comb begin
    first = snap.seen ? snap.first : '0;
    if (snap.seen) begin
      last = snap.last;
    end else if (snap.total != '0) begin
      last = FRAME_BITS'(snap.total - COUNT_BITS'(1));
    end else begin
      last = '0;
    end
    trim    = (snap.total != '0) && (first < last);
    span    = last - first;
    end_off = loop_end - first;

    res_trim = trim;
    if (trim) begin
      res_first = first;
      res_kept  = {1'b0, span} + COUNT_BITS'(1);
      res_nls   = (loop_start >= first) ? (loop_start - first) : '0;
      if (loop_end >= first) begin
        res_nle = (end_off > span) ? span : end_off;
      end else begin
        res_nle = span;
      end
    end else begin
      res_first = '0;
      res_kept  = snap.total;
      res_nls   = loop_start;
      res_nle   = loop_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_move) begin
      m_tuser <= res_trim;
      m_tdata <= {(OUT_DATA_BITS-3*FRAME_BITS-COUNT_BITS)'(0),
                  res_nle, res_nls, res_kept, res_first};
    end
  end

endmodule
